@@ hw/rtl/gpio_pkg.sv @@
`default_nettype none

package gpio_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned HalfPins  = 16;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    OFS_DATA   = 3'd0,
    OFS_DIR    = 3'd1,
    OFS_PAD    = 3'd2,
    OFS_CFG_LO = 3'd3,
    OFS_CFG_HI = 3'd4,
    OFS_MASK   = 3'd5,
    OFS_STATUS = 3'd6,
    OFS_EDGE   = 3'd7
  } ofs_e;

  typedef enum logic [1:0] {
    MODE_LOW  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_RISE = 2'd2,
    MODE_FALL = 2'd3
  } mode_e;

  typedef struct packed {
    logic [WordWidth-1:0] read_data;
    logic [WordWidth-1:0] pad_drive;
    logic [WordWidth-1:0] output_enable;
    logic                 irq_low_pins;
    logic                 irq_high_pins;
  } result_t;

  // Widen a mask of 16 pins to the two-bits-per-pin layout of a config word.
  function automatic logic [WordWidth-1:0] spread16(input logic [HalfPins-1:0] m);
    logic [WordWidth-1:0] r;
    r = '0;
    for (int i = 0; i < HalfPins; i++) begin
      r[2*i +: 2] = {2{m[i]}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gpio_port_with_interrupts.sv @@
`default_nettype none

// GPIO port of up to 32 pins with per-pin edge or level interrupts. Each input
// word is a tick (sample the pads), a bus read or a masked bus write to one of
// eight registers; every word yields exactly one result word, which shows the
// register state after that word took effect. The port takes one word per
// clock while in_stall_o is low, and registers each result; all register and
// interrupt logic sits between the input handshake and the result register.
// A two-entry output stage (result register plus skid register) absorbs
// downstream stalls, so in_stall_o rises only once both entries hold a word.
// Pins at or above PIN_COUNT read as zero and ignore writes.
module gpio_port_with_interrupts #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [2:0]  reg_offset_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [31:0] write_mask_i,
  input  wire logic [31:0] pad_inputs_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      read_data_o,
  output logic [31:0]      pad_drive_o,
  output logic [31:0]      output_enable_o,
  output logic             irq_low_pins_o,
  output logic             irq_high_pins_o
);
  import gpio_pkg::*;

  localparam logic [WordWidth-1:0] PinMask   = {WordWidth{1'b1}} >> (WordWidth - PIN_COUNT);
  localparam logic [WordWidth-1:0] CfgLoMask = spread16(PinMask[HalfPins-1:0]);
  localparam logic [WordWidth-1:0] CfgHiMask = spread16(PinMask[WordWidth-1:HalfPins]);

  logic [WordWidth-1:0] data_q, data_d;
  logic [WordWidth-1:0] dir_q, dir_d;
  logic [WordWidth-1:0] pad_q, pad_d;
  logic [WordWidth-1:0] cfg_lo_q, cfg_lo_d;
  logic [WordWidth-1:0] cfg_hi_q, cfg_hi_d;
  logic [WordWidth-1:0] mask_q, mask_d;
  logic [WordWidth-1:0] status_q, status_d;
  logic [WordWidth-1:0] edge_q, edge_d;

  logic                 in_accept;
  logic                 out_fire;
  cmd_e                 cmd;
  ofs_e                 ofs;
  logic [WordWidth-1:0] pads;
  logic [WordWidth-1:0] wen;
  logic [WordWidth-1:0] hit;
  logic [WordWidth-1:0] rdata;
  logic [WordWidth-1:0] pend;
  logic [2*WordWidth-1:0] cfg_all;
  result_t              res;

  result_t              out_q;
  result_t              skid_q;
  logic                 out_valid_q;
  logic                 skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  assign cmd     = cmd_e'(command_i);
  assign ofs     = ofs_e'(reg_offset_i);
  assign pads    = pad_inputs_i & PinMask;
  assign wen     = write_mask_i & PinMask;
  assign cfg_all = {cfg_hi_q, cfg_lo_q};

  // Per-pin edge or level detection; edge modes compare with the previous sample.
  always_comb begin
    hit = '0;
    for (int p = 0; p < WordWidth; p++) begin
      if (edge_q[p]) begin
        hit[p] = pads[p] ^ pad_q[p];
      end else begin
        case (mode_e'(cfg_all[2*p +: 2]))
          MODE_LOW:  hit[p] = !pads[p];
          MODE_HIGH: hit[p] = pads[p];
          MODE_RISE: hit[p] = pads[p] && !pad_q[p];
          MODE_FALL: hit[p] = !pads[p] && pad_q[p];
          default:   hit[p] = 1'b0;
        endcase
      end
    end
    hit = hit & PinMask;
  end

  always_comb begin
    case (ofs)
      OFS_DATA:   rdata = data_q;
      OFS_DIR:    rdata = dir_q;
      OFS_PAD:    rdata = pad_q;
      OFS_CFG_LO: rdata = cfg_lo_q;
      OFS_CFG_HI: rdata = cfg_hi_q;
      OFS_MASK:   rdata = mask_q;
      OFS_STATUS: rdata = status_q;
      OFS_EDGE:   rdata = edge_q;
      default:    rdata = '0;
    endcase
  end

  always_comb begin
    data_d   = data_q;
    dir_d    = dir_q;
    pad_d    = pad_q;
    cfg_lo_d = cfg_lo_q;
    cfg_hi_d = cfg_hi_q;
    mask_d   = mask_q;
    status_d = status_q;
    edge_d   = edge_q;
    res.read_data = '0;
    case (cmd)
      CMD_TICK: begin
        status_d = status_q | hit;
        pad_d    = pads;
      end
      CMD_READ: begin
        res.read_data = rdata;
      end
      CMD_WRITE: begin
        case (ofs)
          OFS_DATA:   data_d   = (data_q & ~wen) | (write_data_i & wen);
          OFS_DIR:    dir_d    = (dir_q & ~wen) | (write_data_i & wen);
          OFS_CFG_LO: cfg_lo_d = (cfg_lo_q & ~(write_mask_i & CfgLoMask))
                                 | (write_data_i & write_mask_i & CfgLoMask);
          OFS_CFG_HI: cfg_hi_d = (cfg_hi_q & ~(write_mask_i & CfgHiMask))
                                 | (write_data_i & write_mask_i & CfgHiMask);
          OFS_MASK:   mask_d   = (mask_q & ~wen) | (write_data_i & wen);
          // write one to clear
          OFS_STATUS: status_d = status_q & ~(write_data_i & wen);
          OFS_EDGE:   edge_d   = (edge_q & ~wen) | (write_data_i & wen);
          default:    ; // pad status is read only
        endcase
      end
      default: ;
    endcase
    pend = status_d & mask_d;
    res.pad_drive     = data_d;
    res.output_enable = dir_d;
    res.irq_low_pins  = |pend[HalfPins-1:0];
    res.irq_high_pins = |pend[WordWidth-1:HalfPins];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q   <= '0;
      dir_q    <= '0;
      pad_q    <= '0;
      cfg_lo_q <= '0;
      cfg_hi_q <= '0;
      mask_q   <= '0;
      status_q <= '0;
      edge_q   <= '0;
    end else if (in_accept) begin
      data_q   <= data_d;
      dir_q    <= dir_d;
      pad_q    <= pad_d;
      cfg_lo_q <= cfg_lo_d;
      cfg_hi_q <= cfg_hi_d;
      mask_q   <= mask_d;
      status_q <= status_d;
      edge_q   <= edge_d;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_q.read_data;
  assign pad_drive_o     = out_q.pad_drive;
  assign output_enable_o = out_q.output_enable;
  assign irq_low_pins_o  = out_q.irq_low_pins;
  assign irq_high_pins_o = out_q.irq_high_pins;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in front");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_stall_i))
    else $error("skid entry filled while the output was free");

  a_status_sets_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_accept && cmd == CMD_TICK) |=> ((status_q & ~$past(status_q)) == '0))
    else $error("status bit set outside a tick");

  a_sample_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_accept && cmd == CMD_TICK) |=> $stable(pad_q))
    else $error("pad sample changed outside a tick");

  a_unused_pins_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((status_q | pad_q | mask_q | edge_q) & ~PinMask) == '0)
    else $error("unimplemented pin bit set");

endmodule

`default_nettype wire
